// ===== hw/rtl/mcto_pkg.sv =====
package mcto_pkg;

  // Channel count and counter width
  localparam int NUM_CHANNELS = 8;
  localparam int COUNT_WIDTH  = 24;
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Fixed field widths
  localparam int CMD_W     = 3;
  localparam int CHAN_W    = 3;
  localparam int DELAY_W   = 24;
  localparam int STATUS_W  = 3;
  localparam int EXP_W     = 8;
  localparam int CFG_CNT_W = 4;

  // Stream widths (fields packed from bit 0, padded to bytes)
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  // Entry layout in channel memory: {last delay, compare value}
  localparam int ENTRY_W = DELAY_W + COUNT_WIDTH;

  // Commands
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ARM     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REARM   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CANCEL  = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_CHANNEL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RUNNING     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_TIMER    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE_FREE   = 3'd4;

  // Configuration register indexes
  localparam logic REG_CHANNELS_IN_USE = 1'b0;
  localparam logic REG_TIMER_PRESENT   = 1'b1;

  // Reset values of configuration registers
  localparam logic [CFG_CNT_W-1:0] CHANNELS_IN_USE_RST = 4'd4;
  localparam logic                 TIMER_PRESENT_RST   = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [CHAN_W-1:0]  channel_index;
    logic [DELAY_W-1:0] timeout_ticks;
    logic               notify_enable;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CHAN_W-1:0]   granted_channel;
    logic [EXP_W-1:0]    expired_mask;
  } result_t;

  typedef struct packed {
    logic [CFG_CNT_W-1:0] channels_in_use;
    logic                 timer_present;
  } cfg_t;

endpackage

// ===== hw/rtl/multi_channel_timeout_unit.sv =====
// Multi-channel timeout unit.
// Input stream (s_*): one command per transfer; every command yields exactly
// one result transfer on the output stream (m_*), in order.
// Configuration: cfg_we writes cfg_wdata into register cfg_index
// (0 channels in use, 1 timer present); write only while the unit is idle.
// Allocate, release, arm, cancel and unused codes pass from acceptance
// through the result state into the output register that drives m_tvalid;
// rearm first does one memory read before the write-back, a tick a sweep.
// Throughput: one command at a time; a tick holds the unit for the sweep
// that reads the channel memory one entry per cycle.
// Reset (rst, synchronous): counter, channel flags and expiry state clear,
// all memory entries read as zero until written, config returns to 4 / 1.
// Stall: the result waits in the output register while m_tready is low;
// the unit holds its next result and keeps s_tready low until that
// register frees up.
module multi_channel_timeout_unit
  import mcto_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // command[2:0], channel_index[5:3], timeout_ticks[29:6], notify_enable[30]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // status[2:0], granted_channel[5:3], expired_mask[13:6]
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_CNT_W-1:0]  cfg_wdata
);

  cfg_t    cfg;
  cmd_t    cmd;
  logic    core_idle;
  logic    res_valid;
  logic    res_ready;
  result_t res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channels_in_use <= CHANNELS_IN_USE_RST;
      cfg.timer_present   <= TIMER_PRESENT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANNELS_IN_USE: cfg.channels_in_use <= cfg_wdata;
        REG_TIMER_PRESENT:   cfg.timer_present   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Command unpacking
  assign cmd.command       = s_tdata[2:0];
  assign cmd.channel_index = s_tdata[5:3];
  assign cmd.timeout_ticks = s_tdata[29:6];
  assign cmd.notify_enable = s_tdata[30];

  assign s_tready = core_idle;

  mcto_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd_valid(s_tvalid && core_idle),
    .cmd      (cmd),
    .idle     (core_idle),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // Output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {2'b00, res.expired_mask, res.granted_channel, res.status};
    end
  end

endmodule

// ===== hw/rtl/mcto_ram.sv =====
module mcto_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/mcto_core.sv =====
module mcto_core
  import mcto_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    idle,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_REARM = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(NUM_CHANNELS - 1);

  logic [1:0]              state;
  logic [COUNT_WIDTH-1:0]  tick_count;
  logic [NUM_CHANNELS-1:0] alloc_bits;
  logic [NUM_CHANNELS-1:0] run_bits;
  logic [NUM_CHANNELS-1:0] cen_bits;
  logic [NUM_CHANNELS-1:0] ntf_bits;
  logic [NUM_CHANNELS-1:0] ent_valid;
  logic [NUM_CHANNELS-1:0] exp_acc;
  logic [CH_IDX_W-1:0]     sweep_cnt;
  logic                    issue_active;
  logic                    cmp_vld;
  logic [CH_IDX_W-1:0]     rd_idx;
  logic [CH_IDX_W-1:0]     rearm_ch;

  logic                    ram_we;
  logic [CH_IDX_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]      ram_wdata;
  logic                    ram_re;
  logic [CH_IDX_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]      ram_rdata;
  logic [ENTRY_W-1:0]      rd_entry;
  logic [DELAY_W-1:0]      rd_delay;
  logic [COUNT_WIDTH-1:0]  rd_cmp;

  logic [CFG_CNT_W-1:0]    live;
  logic [CH_IDX_W-1:0]     ch_idx;
  logic                    ch_live;
  logic                    ch_exists;
  logic                    free_found;
  logic [CH_IDX_W-1:0]     free_idx;
  logic                    hit;
  logic [NUM_CHANNELS-1:0] exp_final;

  // Effective channel count and index checks
  assign live      = (cfg.channels_in_use > CFG_CNT_W'(NUM_CHANNELS)) ?
                     CFG_CNT_W'(NUM_CHANNELS) : cfg.channels_in_use;
  assign ch_idx    = cmd.channel_index[CH_IDX_W-1:0];
  assign ch_live   = CFG_CNT_W'(cmd.channel_index) < live;
  assign ch_exists = 32'(cmd.channel_index) < NUM_CHANNELS;

  // Lowest free channel among the live ones
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (!free_found && (CFG_CNT_W'(i) < live) && !alloc_bits[i]) begin
        free_found = 1'b1;
        free_idx   = CH_IDX_W'(i);
      end
    end
  end

  // Unwritten entries read as zero
  assign rd_entry = ent_valid[rd_idx] ? ram_rdata : '0;
  assign rd_delay = rd_entry[ENTRY_W-1:COUNT_WIDTH];
  assign rd_cmp   = rd_entry[COUNT_WIDTH-1:0];

  // Expiry match for the entry coming out of memory
  assign hit       = cmp_vld && cen_bits[rd_idx] && (rd_cmp == tick_count);
  always_comb begin
    exp_final = exp_acc;
    if (hit && run_bits[rd_idx] && ntf_bits[rd_idx]) begin
      exp_final[rd_idx] = 1'b1;
    end
  end

  // Memory port control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = sweep_cnt;
    ram_we    = 1'b0;
    ram_waddr = ch_idx;
    ram_wdata = {cmd.timeout_ticks, tick_count + COUNT_WIDTH'(cmd.timeout_ticks)};
    case (state)
      S_IDLE: begin
        if (cmd_valid && cmd.command == CMD_REARM && ch_live) begin
          ram_re    = 1'b1;
          ram_raddr = ch_idx;
        end
        if (cmd_valid && cmd.command == CMD_ARM && ch_live && !run_bits[ch_idx]) begin
          ram_we = 1'b1;
        end
      end
      S_SWEEP: begin
        ram_re = issue_active;
      end
      S_REARM: begin
        ram_we    = 1'b1;
        ram_waddr = rearm_ch;
        ram_wdata = {rd_delay, tick_count + COUNT_WIDTH'(rd_delay)};
      end
      default: begin
      end
    endcase
  end

  mcto_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_CHANNELS)
  ) u_chan_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Read address tracking
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_idx <= ram_raddr;
    end
  end

  // Command sequencer and channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tick_count   <= '0;
      alloc_bits   <= '0;
      run_bits     <= '0;
      cen_bits     <= '0;
      ntf_bits     <= '0;
      ent_valid    <= '0;
      issue_active <= 1'b0;
      cmp_vld      <= 1'b0;
      sweep_cnt    <= '0;
    end else begin
      if (ram_we) begin
        ent_valid[ram_waddr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            res   <= '0;
            state <= S_DONE;
            case (cmd.command)
              CMD_TICK: begin
                tick_count   <= tick_count + 1'b1;
                exp_acc      <= '0;
                sweep_cnt    <= '0;
                issue_active <= 1'b1;
                state        <= S_SWEEP;
              end
              CMD_ALLOC: begin
                if (!cfg.timer_present) begin
                  res.status <= ST_NO_TIMER;
                end else if (!free_found) begin
                  res.status <= ST_NONE_FREE;
                end else begin
                  alloc_bits[free_idx]  <= 1'b1;
                  ntf_bits[free_idx]    <= cmd.notify_enable;
                  res.granted_channel   <= CHAN_W'(free_idx);
                end
              end
              CMD_RELEASE: begin
                if (ch_exists) begin
                  alloc_bits[ch_idx] <= 1'b0;
                end
              end
              CMD_ARM: begin
                if (!ch_live) begin
                  res.status <= ST_BAD_CHANNEL;
                end else if (run_bits[ch_idx]) begin
                  res.status <= ST_RUNNING;
                end else begin
                  run_bits[ch_idx] <= 1'b1;
                  cen_bits[ch_idx] <= 1'b1;
                end
              end
              CMD_REARM: begin
                if (!ch_live) begin
                  res.status <= ST_BAD_CHANNEL;
                end else begin
                  rearm_ch <= ch_idx;
                  state    <= S_REARM;
                end
              end
              CMD_CANCEL: begin
                if (!ch_live) begin
                  res.status <= ST_BAD_CHANNEL;
                end else if (run_bits[ch_idx]) begin
                  run_bits[ch_idx] <= 1'b0;
                  cen_bits[ch_idx] <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SWEEP: begin
          // Issue one read per cycle, compare each entry in the cycle after its read
          cmp_vld <= issue_active;
          if (issue_active) begin
            if (sweep_cnt == LAST_CH) begin
              issue_active <= 1'b0;
            end else begin
              sweep_cnt <= sweep_cnt + 1'b1;
            end
          end
          if (hit) begin
            cen_bits[rd_idx] <= 1'b0;
            run_bits[rd_idx] <= 1'b0;
          end
          exp_acc <= exp_final;
          if (cmp_vld && rd_idx == LAST_CH) begin
            cmp_vld          <= 1'b0;
            res.expired_mask <= EXP_W'(exp_final);
            state            <= S_DONE;
          end
        end
        S_REARM: begin
          run_bits[rearm_ch] <= 1'b1;
          cen_bits[rearm_ch] <= 1'b1;
          state              <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

endmodule

// ===== sim/multi_channel_timeout_unit_tb.sv =====
module multi_channel_timeout_unit_tb;
  import mcto_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Command codes the unit ignores
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_WAIT   = NUM_CHANNELS + 3;
  localparam int MAX_REPORTS  = 40;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // command[2:0], channel_index[5:3], timeout_ticks[29:6], notify_enable[30]
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // status[2:0], granted_channel[5:3], expired_mask[13:6]
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = REG_CHANNELS_IN_USE;
  logic [CFG_CNT_W-1:0]  cfg_wdata = '0;

  multi_channel_timeout_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Predictor state: counter, channel flags, per-channel compare and delay
  logic [CFG_CNT_W-1:0]   ch_in_use = CHANNELS_IN_USE_RST;
  logic                   timer_on  = TIMER_PRESENT_RST;
  logic [COUNT_WIDTH-1:0] tick_now  = '0;
  logic [7:0]             alloc_q   = '0;
  logic [7:0]             run_q     = '0;
  logic [7:0]             cmp_en_q  = '0;
  logic [7:0]             notify_q  = '0;
  logic [COUNT_WIDTH-1:0] cmp_val  [NUM_CHANNELS];
  logic [DELAY_W-1:0]     last_dly [NUM_CHANNELS];

  cmd_t    pending_cmds[$];
  result_t results_due[$];
  cmd_t    drv_cmd = '0;
  bit      cmd_taken = 1'b0;
  bit      idle_on = 1'b1;
  int      gap_left = 0;
  int      quiet_in = 0;
  int      stall_left = 0;
  int      quiet_out = 0;
  int      cmds_queued = 0;
  int      cmds_accepted = 0;
  int      results_checked = 0;
  int      expiry_results = 0;
  int      settings_used = 0;
  int      err_count = 0;
  int      cycle_count = 0;

  initial begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      cmp_val[i]  = '0;
      last_dly[i] = '0;
    end
  end

  function automatic int unsigned live_count();
    return (ch_in_use > NUM_CHANNELS) ? NUM_CHANNELS : ch_in_use;
  endfunction

  function automatic void start_timeout(int unsigned ch, logic [DELAY_W-1:0] dly);
    run_q[ch]    = 1'b1;
    cmp_val[ch]  = tick_now + dly;
    cmp_en_q[ch] = 1'b1;
  endfunction

  // Apply one command to the predictor and return the result it must give
  function automatic result_t timer_apply(cmd_t c);
    result_t     r;
    int unsigned live;
    int unsigned ch;
    bit          found;
    r     = '0;
    live  = live_count();
    ch    = c.channel_index;
    found = 1'b0;
    case (c.command)
      CMD_TICK: begin
        tick_now = tick_now + 1'b1;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (cmp_en_q[i] && cmp_val[i] == tick_now) begin
            cmp_en_q[i] = 1'b0;
            if (run_q[i]) begin
              run_q[i] = 1'b0;
              if (notify_q[i]) r.expired_mask[i] = 1'b1;
            end
          end
        end
      end
      CMD_ALLOC: begin
        if (!timer_on) begin
          r.status = ST_NO_TIMER;
        end else begin
          r.status = ST_NONE_FREE;
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (!found && i < live && !alloc_q[i]) begin
              found               = 1'b1;
              alloc_q[i]          = 1'b1;
              notify_q[i]         = c.notify_enable;
              r.granted_channel   = CHAN_W'(i);
              r.status            = ST_OK;
            end
          end
        end
      end
      CMD_RELEASE: begin
        if (ch < NUM_CHANNELS) alloc_q[ch] = 1'b0;
      end
      CMD_ARM: begin
        if (ch >= live) r.status = ST_BAD_CHANNEL;
        else if (run_q[ch]) r.status = ST_RUNNING;
        else begin
          last_dly[ch] = c.timeout_ticks;
          start_timeout(ch, c.timeout_ticks);
        end
      end
      CMD_REARM: begin
        if (ch >= live) r.status = ST_BAD_CHANNEL;
        else start_timeout(ch, last_dly[ch]);
      end
      CMD_CANCEL: begin
        if (ch >= live) r.status = ST_BAD_CHANNEL;
        else if (run_q[ch]) begin
          run_q[ch]    = 1'b0;
          cmp_en_q[ch] = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (err_count < MAX_REPORTS)
      $display("%0t MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // Command driver: inputs change on the falling edge
  always @(negedge clk) begin : cmd_drive
    logic nv;
    nv = s_tvalid;
    if (cmd_taken) begin
      nv        = 1'b0;
      cmd_taken = 1'b0;
    end
    if (!rst && !nv) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_cmds.size() > 0) begin
        drv_cmd = pending_cmds.pop_front();
        nv      = 1'b1;
        if (quiet_in > 0) quiet_in--;
        else if (idle_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 3);
        else if ($urandom_range(0, 149) == 0) quiet_in = $urandom_range(20, 60);
      end
    end
    s_tvalid <= nv;
    s_tdata  <= {1'b0, drv_cmd.notify_enable, drv_cmd.timeout_ticks,
                 drv_cmd.channel_index, drv_cmd.command};
  end

  // Result backpressure in short bursts
  always @(negedge clk) begin : result_ready
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (quiet_out > 0) quiet_out--;
      else if (idle_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 3);
      else if ($urandom_range(0, 149) == 0) quiet_out = $urandom_range(20, 60);
    end
  end

  // Monitor: predict on each command transfer, check each result transfer
  always @(posedge clk) begin : monitor
    result_t want;
    cycle_count++;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        results_due.push_back(timer_apply(drv_cmd));
        cmds_accepted++;
        cmd_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with none pending", m_tdata, 0);
        end else begin
          want = results_due.pop_front();
          results_checked++;
          if (want.expired_mask != 0) expiry_results++;
          if (m_tdata[2:0] != want.status)
            report_mismatch("status", m_tdata[2:0], want.status);
          if (m_tdata[5:3] != want.granted_channel)
            report_mismatch("granted_channel", m_tdata[5:3], want.granted_channel);
          if (m_tdata[13:6] != want.expired_mask)
            report_mismatch("expired_mask", m_tdata[13:6], want.expired_mask);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("Timeout after %0d cycles", cycle_count);
    $display("Test completed with failures");
    $finish;
  end

  task automatic push_cmd(logic [CMD_W-1:0] op, logic [CHAN_W-1:0] ch,
                          logic [DELAY_W-1:0] dly, logic ntf);
    cmd_t c;
    c.command       = op;
    c.channel_index = ch;
    c.timeout_ticks = dly;
    c.notify_enable = ntf;
    pending_cmds.push_back(c);
    cmds_queued++;
  endtask

  // Register writes go out only while the unit is idle
  task automatic write_reg(logic idx, logic [CFG_CNT_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_CHANNELS_IN_USE) ch_in_use = val;
    else timer_on = val[0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [CFG_CNT_W-1:0] count, logic present);
    write_reg(REG_CHANNELS_IN_USE, count);
    write_reg(REG_TIMER_PRESENT, {{(CFG_CNT_W-1){1'b0}}, present});
    settings_used++;
  endtask

  task automatic wait_drained();
    while (cmds_accepted != cmds_queued || results_due.size() != 0) @(negedge clk);
  endtask

  // Mostly short delays so timeouts really expire; a few huge or zero ones
  task automatic queue_random(int n);
    int                 r;
    int unsigned        live;
    logic [CMD_W-1:0]   op;
    logic [CHAN_W-1:0]  ch;
    logic [DELAY_W-1:0] dly;
    for (int k = 0; k < n; k++) begin
      live = live_count();
      r = $urandom_range(0, 99);
      if (r < 38) op = CMD_TICK;
      else if (r < 48) op = CMD_ALLOC;
      else if (r < 57) op = CMD_RELEASE;
      else if (r < 77) op = CMD_ARM;
      else if (r < 86) op = CMD_REARM;
      else if (r < 96) op = CMD_CANCEL;
      else op = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
      if (live > 0 && $urandom_range(0, 4) != 0) ch = CHAN_W'($urandom_range(0, live - 1));
      else ch = CHAN_W'($urandom_range(0, 7));
      r = $urandom_range(0, 9);
      if (r < 7) dly = DELAY_W'($urandom_range(1, 12));
      else if (r == 7) dly = '0;
      else if (r == 8) dly = DELAY_W'($urandom());
      else dly = DELAY_W'($urandom_range(24'hFFFFF0, 24'hFFFFFF));
      push_cmd(op, ch, dly, $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin : stimulus
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    settings_used = 1;

    // Directed pass at the reset setting: four channels, timer present
    push_cmd(CMD_TICK, 3'd0, 24'd0, 1'b0);
    push_cmd(CMD_ALLOC, 3'd7, 24'hFFFFFF, 1'b1);
    push_cmd(CMD_ALLOC, 3'd0, 24'd0, 1'b0);
    push_cmd(CMD_ARM, 3'd0, 24'd2, 1'b0);
    push_cmd(CMD_ARM, 3'd0, 24'd5, 1'b0);          // already running
    push_cmd(CMD_ARM, 3'd4, 24'd1, 1'b0);          // beyond the live count
    push_cmd(CMD_ARM, 3'd1, 24'd1, 1'b0);
    push_cmd(CMD_TICK, 3'd0, 24'd0, 1'b0);         // silent expiry
    push_cmd(CMD_TICK, 3'd0, 24'd0, 1'b0);         // reported expiry
    push_cmd(CMD_REARM, 3'd0, 24'd0, 1'b0);
    push_cmd(CMD_REARM, 3'd0, 24'd0, 1'b0);        // restart while running
    push_cmd(CMD_CANCEL, 3'd0, 24'd0, 1'b0);
    push_cmd(CMD_CANCEL, 3'd0, 24'd0, 1'b0);       // already stopped
    push_cmd(CMD_CANCEL, 3'd7, 24'd0, 1'b0);
    push_cmd(CMD_REARM, 3'd2, 24'd0, 1'b0);        // never armed: zero delay
    push_cmd(CMD_ARM, 3'd3, 24'hFFFFFF, 1'b1);     // compare wraps round
    push_cmd(CMD_RELEASE, 3'd5, 24'd0, 1'b0);      // never allocated
    push_cmd(CMD_RELEASE, 3'd0, 24'd0, 1'b0);
    push_cmd(CMD_SPARE6, 3'd7, 24'hFFFFFF, 1'b1);
    push_cmd(CMD_SPARE7, 3'd7, 24'hFFFFFF, 1'b1);
    for (int i = 0; i < 4; i++) push_cmd(CMD_ALLOC, 3'd0, 24'd0, 1'b1);
    push_cmd(CMD_ALLOC, 3'd0, 24'd0, 1'b1);        // none free
    wait_drained();

    // All eight channels; leave channel 7 running into a smaller setting
    set_config(4'd8, 1'b1);
    queue_random(450);
    for (int i = 0; i < NUM_CHANNELS; i++) push_cmd(CMD_RELEASE, CHAN_W'(i), 24'd0, 1'b0);
    for (int i = 0; i < NUM_CHANNELS; i++) push_cmd(CMD_ALLOC, 3'd0, 24'd0, 1'b1);
    push_cmd(CMD_CANCEL, 3'd7, 24'd0, 1'b0);
    push_cmd(CMD_ARM, 3'd7, 24'd6, 1'b0);
    wait_drained();

    set_config(4'd1, 1'b1);
    for (int i = 0; i < 8; i++) push_cmd(CMD_TICK, 3'd0, 24'd0, 1'b0);
    queue_random(200);
    wait_drained();

    set_config(4'd0, 1'b1);
    queue_random(100);
    wait_drained();

    set_config(4'd15, 1'b1);
    queue_random(300);
    wait_drained();

    set_config(4'd5, 1'b0);
    queue_random(200);
    wait_drained();

    set_config(4'd3, 1'b1);
    queue_random(200);
    wait_drained();

    // Closing stretch at full rate on both sides
    set_config(4'd8, 1'b1);
    idle_on = 1'b0;
    queue_random(350);
    wait_drained();

    repeat (DRAIN_WAIT + 8) @(negedge clk);
    $display("Sent %0d commands across %0d register settings", cmds_accepted, settings_used);
    $display("Checked %0d results, %0d of them with expiries", results_checked,
             expiry_results);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
